[hw/rtl/ole_pkg.sv]
// Shared types and constants for the ordered list engine.
package ole_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_SORTED     = 3'd2;
    localparam logic [2:0] OP_FIND       = 3'd3;
    localparam logic [2:0] OP_POP_FRONT  = 3'd4;
    localparam logic [2:0] OP_DELETE     = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] item_key;
        logic signed [31:0] item_value;
        logic               descending;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_value;
        logic [CNT_W-1:0]   entry_count;
    } rsp_t;

    typedef struct packed {
        logic load_new;
        logic from_left;
        logic from_right;
    } cell_ctrl_t;

    typedef struct packed {
        logic key_eq;
        logic val_eq;
        logic val_gt;
        logic val_lt;
    } cell_flags_t;

endpackage

[hw/rtl/ole_cell.sv]
// One list slot: holds a key/value entry, compares it and shifts it to a neighbor.
module ole_cell (
    input  logic                 clk,
    input  ole_pkg::cell_ctrl_t  ctrl,
    input  logic signed [31:0]   cmp_key,
    input  logic signed [31:0]   cmp_value,
    input  logic signed [31:0]   left_key,
    input  logic signed [31:0]   left_value,
    input  logic signed [31:0]   right_key,
    input  logic signed [31:0]   right_value,
    output logic signed [31:0]   key,
    output logic signed [31:0]   value,
    output ole_pkg::cell_flags_t flags
);

    logic signed [31:0] key_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] key_next;
    logic signed [31:0] value_next;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.load_new)
        begin
            key_next   = cmp_key;
            value_next = cmp_value;
        end
        else if (ctrl.from_left)
        begin
            key_next   = left_key;
            value_next = left_value;
        end
        else if (ctrl.from_right)
        begin
            key_next   = right_key;
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key          = key_reg;
    assign value        = value_reg;
    assign flags.key_eq = (key_reg == cmp_key);
    assign flags.val_eq = (value_reg == cmp_value);
    assign flags.val_gt = (value_reg > cmp_value);
    assign flags.val_lt = (value_reg < cmp_value);

endmodule

[hw/rtl/ordered_list_engine.sv]
// Top level of the ordered list engine: command register, cell row control, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------
//  request | req_valid | req_stall | req (ole_pkg::req_t)
//  result  | rsp_valid | rsp_stall | rsp (ole_pkg::rsp_t)
//
// Each request has a transfer edge, then an execute edge in which
// every cell compares against the command and the whole row shifts at once.
// Execute waits while a previous result is held and stalled; req_stall is high
// from transfer until execute. Reset empties the list; entries are never cleared.
module ordered_list_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ole_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ole_pkg::rsp_t rsp
);

    localparam int DEPTH = ole_pkg::LIST_DEPTH;
    localparam int CW    = ole_pkg::CNT_W;

    ole_pkg::req_t    cmd_reg;
    logic             busy_reg;
    logic             busy_next;
    ole_pkg::rsp_t    rsp_reg;
    ole_pkg::rsp_t    rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic             accept;
    logic             exec;
    logic             full;
    logic             empty;
    logic [DEPTH:0]   count_pow;
    logic [DEPTH:0]   valid_wide;
    logic [DEPTH-1:0] valid_v;
    logic [DEPTH-1:0] count_oh;
    logic [DEPTH-1:0] key_eq_v;
    logic [DEPTH-1:0] val_eq_v;
    logic [DEPTH-1:0] val_gt_v;
    logic [DEPTH-1:0] val_lt_v;
    logic [DEPTH-1:0] target;
    logic [DEPTH-1:0] low;
    logic [DEPTH-1:0] at_or_above;
    logic             do_ins;
    logic             do_del;
    logic             found;
    logic [1:0]       status;
    logic signed [31:0] sel_key;
    logic signed [31:0] sel_value;

    logic signed [31:0]   cell_key   [DEPTH];
    logic signed [31:0]   cell_value [DEPTH];
    ole_pkg::cell_flags_t cell_flags [DEPTH];
    ole_pkg::cell_ctrl_t  cell_ctrl  [DEPTH];

    assign accept    = req_valid && !busy_reg;
    assign exec      = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign count_pow  = {{DEPTH{1'b0}}, 1'b1} << count_reg;
    assign valid_wide = count_pow - 1'b1;
    assign valid_v    = valid_wide[DEPTH-1:0];
    assign count_oh   = count_pow[DEPTH-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [31:0] lk;
            logic signed [31:0] lv;
            logic signed [31:0] rk;
            logic signed [31:0] rv;
            if (gi == 0)
            begin : g_first
                assign lk = cmd_reg.item_key;
                assign lv = cmd_reg.item_value;
            end
            else
            begin : g_mid_l
                assign lk = cell_key[gi-1];
                assign lv = cell_value[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign rk = cell_key[gi];
                assign rv = cell_value[gi];
            end
            else
            begin : g_mid_r
                assign rk = cell_key[gi+1];
                assign rv = cell_value[gi+1];
            end

            ole_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl[gi]),
                .cmp_key     (cmd_reg.item_key),
                .cmp_value   (cmd_reg.item_value),
                .left_key    (lk),
                .left_value  (lv),
                .right_key   (rk),
                .right_value (rv),
                .key         (cell_key[gi]),
                .value       (cell_value[gi]),
                .flags       (cell_flags[gi])
            );

            assign key_eq_v[gi] = cell_flags[gi].key_eq & valid_v[gi];
            assign val_eq_v[gi] = cell_flags[gi].val_eq & valid_v[gi];
            assign val_gt_v[gi] = cell_flags[gi].val_gt & valid_v[gi];
            assign val_lt_v[gi] = cell_flags[gi].val_lt & valid_v[gi];

            assign cell_ctrl[gi].load_new   = exec && do_ins && low[gi];
            assign cell_ctrl[gi].from_left  = exec && do_ins && at_or_above[gi] && !low[gi];
            assign cell_ctrl[gi].from_right = exec && do_del && at_or_above[gi];
        end
    endgenerate

    always_comb
    begin
        target = '0;
        do_ins = 1'b0;
        do_del = 1'b0;
        found  = 1'b0;
        status = ole_pkg::ST_OK;
        case (cmd_reg.operation)
            ole_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                    status = ole_pkg::ST_FULL;
                else
                begin
                    do_ins = 1'b1;
                    target = {{(DEPTH-1){1'b0}}, 1'b1};
                end
            end
            ole_pkg::OP_PUSH_BACK:
            begin
                if (full)
                    status = ole_pkg::ST_FULL;
                else
                begin
                    do_ins = 1'b1;
                    target = count_oh;
                end
            end
            ole_pkg::OP_SORTED:
            begin
                if (full)
                    status = ole_pkg::ST_FULL;
                else if (|val_eq_v)
                    status = ole_pkg::ST_DUPLICATE;
                else
                begin
                    do_ins = 1'b1;
                    target = (cmd_reg.descending ? val_lt_v : val_gt_v) | count_oh;
                end
            end
            ole_pkg::OP_FIND, ole_pkg::OP_DELETE:
            begin
                if (|key_eq_v)
                begin
                    found  = 1'b1;
                    do_del = (cmd_reg.operation == ole_pkg::OP_DELETE);
                    target = key_eq_v;
                end
                else
                    status = ole_pkg::ST_NOT_FOUND;
            end
            ole_pkg::OP_POP_FRONT:
            begin
                if (empty)
                    status = ole_pkg::ST_NOT_FOUND;
                else
                begin
                    found  = 1'b1;
                    do_del = 1'b1;
                    target = {{(DEPTH-1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                status = ole_pkg::ST_OK;
            end
        endcase
    end

    // first set bit of target marks the position; everything from there up shifts
    assign low         = target & (~target + 1'b1);
    assign at_or_above = ~(low - 1'b1);

    always_comb
    begin
        sel_key   = '0;
        sel_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_key   = sel_key   | (low[i] ? cell_key[i]   : 32'sd0);
            sel_value = sel_value | (low[i] ? cell_value[i] : 32'sd0);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        busy_next      = busy_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (accept)
            busy_next = 1'b1;
        if (exec)
        begin
            busy_next = 1'b0;
            if (cmd_reg.operation == ole_pkg::OP_CLEAR)
                count_next = '0;
            else if (do_ins)
                count_next = count_reg + 1'b1;
            else if (do_del)
                count_next = count_reg - 1'b1;
            rsp_next.status      = status;
            rsp_next.out_key     = found ? sel_key : 32'sd0;
            rsp_next.out_value   = found ? sel_value : 32'sd0;
            rsp_next.entry_count = count_next;
            rsp_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= req;
        rsp_reg <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above list depth");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.entry_count == count_reg)
        else $error("result count differs from held count");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && do_del) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("removal did not shrink the list by one");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the ordered list engine: directed and random list operations.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam int         CYCLE_LIMIT = 200000;

    typedef enum int {FILL, MIXED, DRAIN, NOISE} traffic_t;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int send_idle = 32;
    int recv_idle = 51;
    int sent_items = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // predicted list contents, position 0 is the front
    logic signed [31:0] list_key [LIST_DEPTH];
    logic signed [31:0] list_val [LIST_DEPTH];
    int held = 0;
    rsp_t expected_rsp [$];

    ordered_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void insert_at(input int pos, input logic signed [31:0] k,
                                      input logic signed [31:0] v);
        for (int i = held; i > pos; i--)
        begin
            list_key[i] = list_key[i-1];
            list_val[i] = list_val[i-1];
        end
        list_key[pos] = k;
        list_val[pos] = v;
        held++;
    endfunction

    function automatic void remove_at(input int pos);
        for (int i = pos; i + 1 < held; i++)
        begin
            list_key[i] = list_key[i+1];
            list_val[i] = list_val[i+1];
        end
        held--;
    endfunction

    function automatic rsp_t apply_op(input req_t item);
        rsp_t res;
        logic signed [31:0] k;
        logic signed [31:0] v;
        int pos;
        int hit;
        res = '0;
        k = item.item_key;
        v = item.item_value;
        hit = -1;
        case (item.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                    insert_at((item.operation == OP_PUSH_FRONT) ? 0 : held, k, v);
            end
            OP_SORTED:
            begin
                for (int i = 0; i < held && hit < 0; i++)
                    if (list_val[i] == v)
                        hit = i;
                if (held >= LIST_DEPTH)
                    res.status = ST_FULL;
                else if (hit >= 0)
                    res.status = ST_DUPLICATE;
                else
                begin
                    pos = held;
                    for (int i = held - 1; i >= 0; i--)
                        if (item.descending ? (list_val[i] < v) : (list_val[i] > v))
                            pos = i;
                    insert_at(pos, k, v);
                end
            end
            OP_FIND, OP_DELETE:
            begin
                for (int i = 0; i < held && hit < 0; i++)
                    if (list_key[i] == k)
                        hit = i;
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.out_key = list_key[hit];
                    res.out_value = list_val[hit];
                    if (item.operation == OP_DELETE)
                        remove_at(hit);
                end
            end
            OP_POP_FRONT:
            begin
                if (held == 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.out_key = list_key[0];
                    res.out_value = list_val[0];
                    remove_at(0);
                end
            end
            OP_CLEAR:
                held = 0;
            default:
                ;
        endcase
        res.entry_count = held[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                fail_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.out_key !== want.out_key)
                begin
                    $error("out_key: expected %0d, actual %0d", want.out_key, rsp.out_key);
                    fail_count++;
                end
                if (rsp.out_value !== want.out_value)
                begin
                    $error("out_value: expected %0d, actual %0d",
                           want.out_value, rsp.out_value);
                    fail_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, rsp.entry_count);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(input req_t item);
        // each cycle the sender stays idle with the given odds
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp.push_back(apply_op(item));
        sent_items++;
    endtask

    function automatic req_t make_cmd(input logic [2:0] op, input logic signed [31:0] k,
                                      input logic signed [31:0] v, input logic desc);
        req_t item;
        item.operation = op;
        item.item_key = k;
        item.item_value = v;
        item.descending = desc;
        return item;
    endfunction

    function automatic req_t make_item(input traffic_t mode, input logic desc_order);
        req_t item;
        int p;
        int sel;
        logic signed [31:0] k;
        logic signed [31:0] v;
        p = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        case (mode)
            FILL:    item.operation = (p < 55) ? (p < 28 ? OP_PUSH_FRONT : OP_PUSH_BACK)
                                               : OP_SORTED;
            DRAIN:   item.operation = (p < 45) ? OP_POP_FRONT
                                               : ((p < 85) ? OP_DELETE : OP_FIND);
            NOISE:   item.operation = 3'($urandom_range(0, 7));
            default:
            begin
                if (p < 20)      item.operation = OP_PUSH_FRONT;
                else if (p < 35) item.operation = OP_PUSH_BACK;
                else if (p < 55) item.operation = OP_SORTED;
                else if (p < 70) item.operation = OP_FIND;
                else if (p < 82) item.operation = OP_POP_FRONT;
                else if (p < 95) item.operation = OP_DELETE;
                else if (p < 97) item.operation = OP_CLEAR;
                else             item.operation = OP_UNUSED;
            end
        endcase
        // keys: existing entries, a small pool with repeats, or anything
        if (mode == NOISE || sel >= 8)
            k = $urandom;
        else if (sel < 5 && held > 0)
            k = list_key[$urandom_range(0, held - 1)];
        else
        begin
            k = $urandom_range(0, 15);
            k = k - 8;
        end
        sel = $urandom_range(0, 9);
        if (mode == NOISE || sel >= 7)
            v = $urandom;
        else if (sel < 3 && held > 0)
            v = list_val[$urandom_range(0, held - 1)];
        else
        begin
            v = $urandom_range(0, 127);
            v = v - 64;
        end
        if (mode == DRAIN && item.operation == OP_DELETE && held > 0)
            k = list_key[$urandom_range(0, held - 1)];
        item.item_key = k;
        item.item_value = v;
        if (item.operation == OP_SORTED && mode != NOISE && $urandom_range(0, 9) != 0)
            item.descending = desc_order;
        else
            item.descending = 1'($urandom_range(0, 1));
        return item;
    endfunction

    task automatic test_empty_list();
        send_item(make_cmd(OP_POP_FRONT, 32'sd0, 32'sd0, 1'b0));
        send_item(make_cmd(OP_FIND, 32'sd3, 32'sd0, 1'b1));
        send_item(make_cmd(OP_DELETE, -32'sd1, 32'sd0, 1'b0));
        send_item(make_cmd(OP_UNUSED, -32'sd1, -32'sd1, 1'b1));
        send_item(make_cmd(OP_CLEAR, 32'sd0, 32'sd0, 1'b0));
    endtask

    task automatic test_push_and_lookup();
        send_item(make_cmd(OP_PUSH_FRONT, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
        send_item(make_cmd(OP_PUSH_BACK, 32'h7fff_ffff, 32'h8000_0000, 1'b1));
        send_item(make_cmd(OP_PUSH_FRONT, 32'sd5, 32'sd0, 1'b0));
        send_item(make_cmd(OP_PUSH_BACK, 32'sd5, -32'sd1, 1'b0));
        send_item(make_cmd(OP_FIND, 32'sd5, 32'sd0, 1'b0));
        send_item(make_cmd(OP_FIND, 32'sd9, 32'sd0, 1'b0));
        send_item(make_cmd(OP_DELETE, 32'sd5, 32'sd0, 1'b0));
        send_item(make_cmd(OP_POP_FRONT, 32'sd0, 32'sd0, 1'b0));
        send_item(make_cmd(OP_CLEAR, 32'sd0, 32'sd0, 1'b0));
    endtask

    task automatic test_sorted_insert();
        send_item(make_cmd(OP_SORTED, 32'sd1, 32'sd10, 1'b0));
        send_item(make_cmd(OP_SORTED, 32'sd2, -32'sd5, 1'b0));
        send_item(make_cmd(OP_SORTED, 32'sd3, 32'sd20, 1'b0));
        send_item(make_cmd(OP_SORTED, 32'sd4, 32'sd15, 1'b0));
        // equal value at the head, then at the tail
        send_item(make_cmd(OP_SORTED, 32'sd5, -32'sd5, 1'b0));
        send_item(make_cmd(OP_SORTED, 32'sd6, 32'sd20, 1'b1));
        send_item(make_cmd(OP_CLEAR, 32'sd0, 32'sd0, 1'b1));
        send_item(make_cmd(OP_SORTED, 32'sd7, 32'sd0, 1'b1));
        send_item(make_cmd(OP_SORTED, 32'sd8, 32'h7fff_ffff, 1'b1));
        send_item(make_cmd(OP_SORTED, 32'sd9, 32'h8000_0000, 1'b1));
        send_item(make_cmd(OP_SORTED, 32'sd10, 32'h7fff_ffff, 1'b1));
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        traffic_t mode;
        logic desc_order;
        target = sent_items + n_items;
        while (sent_items < target)
        begin
            mode = traffic_t'($urandom_range(0, 3));
            desc_order = 1'($urandom_range(0, 1));
            case (mode)
                FILL:
                begin
                    while (held < LIST_DEPTH)
                        send_item(make_item(FILL, desc_order));
                    repeat (3) send_item(make_item(FILL, desc_order));
                end
                DRAIN:
                begin
                    while (held > 0)
                        send_item(make_item(DRAIN, desc_order));
                    repeat (2) send_item(make_item(DRAIN, desc_order));
                end
                default:
                    repeat ($urandom_range(10, 40)) send_item(make_item(mode, desc_order));
            endcase
        end
    endtask

    initial
    begin
        req_valid <= 1'b0;
        req <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_push_and_lookup();
        test_sorted_insert();

        test_random_traffic(230);
        send_idle = 51;
        recv_idle = 32;
        test_random_traffic(230);
        send_idle = 0;
        recv_idle = 0;
        test_random_traffic(230);

        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
